// ===== design/plti_pkg.sv =====
package plti_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 9;
	localparam int TIME_W      = 32;
	localparam int VAL_W       = 32;
	localparam int NUM_W       = 64;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_SEARCH,
		ST_RD_LEFT,
		ST_RD_RIGHT,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} plti_state_t;

endpackage

// ===== design/piecewise_linear_table_interp_core.sv =====
// Breakpoint table interpolator. A word with func low stores one breakpoint
// in the accept cycle and busy never rises. A query word raises busy until
// its result strobe: two reads for the table ends, one binary search step
// per cycle (up to eight for a full table), two reads for the interval,
// two multiply steps and a 32-step divider with a start state and a wait
// for its done; clamped and single-point queries strobe straight after the
// end reads, and a zero-length or reversed interval straight after the
// interval reads. The next word is taken in the cycle after the strobe.
// done is high for exactly one cycle with result_value and the range flags,
// and the receiver cannot hold it off.
module piecewise_linear_table_interp_core import plti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic [7:0]              point_index,
	input  logic [TIME_W-1:0]       point_time,
	input  logic signed [VAL_W-1:0] point_value,
	input  logic [TIME_W-1:0]       query_time,
	output logic                    done,
	output logic signed [VAL_W-1:0] result_value,
	output logic                    below_range,
	output logic                    above_range
);

	plti_state_t state_q, state_n;

	logic [CNT_W-1:0]            point_count_q;
	logic [TIME_W+VAL_W-1:0]     bp_mem_q [TABLE_DEPTH];
	logic [TIME_W+VAL_W-1:0]     rd_data_q;
	logic [IDX_W-1:0]            rd_addr;
	logic [TIME_W-1:0]           rd_time;
	logic signed [VAL_W-1:0]     rd_val;

	logic [TIME_W-1:0]           t_q, t1_q, t2_q;
	logic signed [VAL_W-1:0]     v1_q, v2_q, res_q;
	logic                        below_q, above_q;
	logic [IDX_W-1:0]            last_q, lo_q, hi_q, mid_q;
	logic [TIME_W-1:0]           da_q, db_q, dt_q;
	logic signed [NUM_W-1:0]     p1_q, p2_q, num_q;

	logic                        accept, wr_en, q_start;
	logic [CNT_W:0]              active;
	logic [IDX_W-1:0]            last_c;
	logic                        go_right;
	logic [IDX_W-1:0]            lo_n, hi_n, mid_n;
	logic [IDX_W:0]              mid_sum;
	logic [TIME_W-1:0]           tc;
	logic signed [TIME_W+VAL_W:0] prod1, prod2;
	logic                        div_start, div_done;
	logic signed [VAL_W-1:0]     div_quot;

	assign accept  = start && !busy;
	assign wr_en   = accept && (func == FUNC_WRITE) && (32'(point_index) < TABLE_DEPTH);
	assign q_start = accept && (func == FUNC_QUERY);

	always_comb begin
		priority if (point_count_q == '0)
			active = (CNT_W+1)'(1);
		else if (32'(point_count_q) > TABLE_DEPTH)
			active = (CNT_W+1)'(TABLE_DEPTH);
		else
			active = {1'b0, point_count_q};
	end
	assign last_c = IDX_W'(active - 1'b1);

	assign rd_time = rd_data_q[TIME_W+VAL_W-1:VAL_W];
	assign rd_val  = rd_data_q[VAL_W-1:0];

	assign go_right = t_q > rd_time;
	assign lo_n     = go_right ? mid_q : lo_q;
	assign hi_n     = go_right ? hi_q : mid_q;
	assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n    = mid_sum[IDX_W:1];

	always_comb begin
		priority if (t_q < t1_q)
			tc = t1_q;
		else if (t_q > t2_q)
			tc = t2_q;
		else
			tc = t_q;
	end

	assign prod1 = $signed({1'b0, da_q}) * v1_q;
	assign prod2 = $signed({1'b0, db_q}) * v2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			point_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bp_mem_q[IDX_W'(point_index)] <= {point_time, point_value};
		end
		rd_data_q <= bp_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:     if (q_start) state_n = ST_RD_FIRST;
			ST_RD_FIRST: state_n = ST_RD_LAST;
			ST_RD_LAST: begin
				if (t_q < t1_q || t_q > rd_time || last_q == '0)
					state_n = ST_OUT;
				else
					state_n = ST_SEARCH;
			end
			ST_SEARCH:   if (mid_n == lo_n) state_n = ST_RD_LEFT;
			ST_RD_LEFT:  state_n = ST_RD_RIGHT;
			ST_RD_RIGHT: state_n = (rd_time <= t1_q) ? ST_OUT : ST_PREP;
			ST_PREP:     state_n = ST_MUL1;
			ST_MUL1:     state_n = ST_MUL2;
			ST_MUL2:     state_n = ST_SUM;
			ST_SUM:      state_n = ST_DIV_GO;
			ST_DIV_GO:   state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_n = ST_OUT;
			ST_OUT:      state_n = ST_IDLE;
			default:     state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != ST_IDLE;
		done      = state_q == ST_OUT;
		div_start = state_q == ST_DIV_GO;
		unique case (state_q)
			ST_RD_FIRST: rd_addr = last_q;
			ST_RD_LAST:  rd_addr = last_q >> 1;
			ST_SEARCH:   rd_addr = mid_n;
			ST_RD_LEFT:  rd_addr = lo_q + 1'b1;
			default:     rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q     <= query_time;
				last_q  <= last_c;
				below_q <= 1'b0;
				above_q <= 1'b0;
			end
			ST_RD_FIRST: begin
				t1_q <= rd_time;
				v1_q <= rd_val;
			end
			ST_RD_LAST: begin
				lo_q  <= '0;
				hi_q  <= last_q;
				mid_q <= last_q >> 1;
				priority if (t_q < t1_q) begin
					res_q   <= v1_q;
					below_q <= 1'b1;
				end else if (t_q > rd_time) begin
					res_q   <= rd_val;
					above_q <= 1'b1;
				end else begin
					res_q <= v1_q;
				end
			end
			ST_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			ST_RD_LEFT: begin
				t1_q <= rd_time;
				v1_q <= rd_val;
			end
			ST_RD_RIGHT: begin
				t2_q  <= rd_time;
				v2_q  <= rd_val;
				res_q <= v1_q;
			end
			ST_PREP: begin
				da_q <= t2_q - tc;
				db_q <= tc - t1_q;
				dt_q <= t2_q - t1_q;
			end
			ST_MUL1:     p1_q <= prod1[NUM_W-1:0];
			ST_MUL2:     p2_q <= prod2[NUM_W-1:0];
			ST_SUM:      num_q <= p1_q + p2_q;
			ST_DIV_WAIT: if (div_done) res_q <= div_quot;
			default: begin
			end
		endcase
	end

	plti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (dt_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign result_value = res_q;
	assign below_range  = below_q;
	assign above_range  = above_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(below_range && above_range)) else $error("both range flags set");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_WRITE) |=> !busy) else $error("write left block busy");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_QUERY) |=> busy) else $error("query not started");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q < hi_q && mid_q < hi_q))
		else $error("search bounds crossed");

endmodule

// ===== design/plti_div.sv =====
module plti_div import plti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [TIME_W-1:0]       den,
	output logic                    done,
	output logic signed [VAL_W-1:0] quot
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    sh_q;
	logic [TIME_W-1:0]    den_q;
	logic                 neg_q;
	logic [NUM_W-1:0]     mag;
	logic [TIME_W+1:0]    trial;

	assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign trial = {1'b0, rem_q, sh_q[TIME_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag[NUM_W-1:TIME_W];
			sh_q  <= mag[TIME_W-1:0];
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (run_q) begin
			if (!trial[TIME_W+1]) begin
				rem_q <= trial[TIME_W-1:0];
				sh_q  <= {sh_q[TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[TIME_W-2:0], sh_q[TIME_W-1]};
				sh_q  <= {sh_q[TIME_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? VAL_W'(-sh_q) : VAL_W'(sh_q);

endmodule

// ===== tb/testbench.sv =====
module testbench import plti_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET = 1300;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam int IDLE_PCT = 22;

	typedef enum logic {
		ROW_WORD,
		ROW_COUNT
	} row_kind_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    below;
		logic                    above;
	} interp_result_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CNT_W-1:0]   count;
		logic               fn;
		logic [7:0]         idx;
		logic [TIME_W-1:0]  pt;
		logic [VAL_W-1:0]   pv;
		logic [TIME_W-1:0]  qt;
		logic               typed;
		logic [VAL_W-1:0]   exp_val;
		logic               exp_below;
		logic               exp_above;
	} plan_row_t;

	localparam int PLAN_LEN = 27;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd0, 32'd100, 32'h0001_0000, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd1, 32'd200, 32'h0003_0000, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd100,
			1'b1, 32'h0001_0000, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd200,
			1'b1, 32'h0003_0000, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd150,
			1'b1, 32'h0002_0000, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b1, 32'h0001_0000, 1'b1, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
			1'b1, 32'h0003_0000, 1'b0, 1'b1},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd99,
			1'b1, 32'h0001_0000, 1'b1, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd201,
			1'b1, 32'h0003_0000, 1'b0, 1'b1},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd137,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
			1'b1, 32'h8000_0000, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'h8000_0000,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd1,
			1'b0, 32'd0, 1'b0, 1'b0},
		// zero-length interval
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd1, 32'd0, 32'd5, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd1,
			1'b1, 32'd5, 1'b0, 1'b1},
		// single point table
		'{ROW_COUNT, 9'd1, FUNC_WRITE, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_WRITE, 8'd0, 32'd1000, 32'hFFFF_FFFB, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd1000,
			1'b1, 32'hFFFF_FFFB, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd999,
			1'b1, 32'hFFFF_FFFB, 1'b1, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd1001,
			1'b1, 32'hFFFF_FFFB, 1'b0, 1'b1},
		// count of zero acts as one point
		'{ROW_COUNT, 9'd0, FUNC_WRITE, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b0, 32'd0, 1'b0, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'd0,
			1'b1, 32'hFFFF_FFFB, 1'b1, 1'b0},
		'{ROW_WORD,  9'd0, FUNC_QUERY, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
			1'b1, 32'hFFFF_FFFB, 1'b0, 1'b1}
	};

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CNT_W-1:0]        cfg_data = '0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    func = FUNC_WRITE;
	logic [7:0]              point_index = '0;
	logic [TIME_W-1:0]       point_time = '0;
	logic signed [VAL_W-1:0] point_value = '0;
	logic [TIME_W-1:0]       query_time = '0;
	logic                    done;
	logic signed [VAL_W-1:0] result_value;
	logic                    below_range;
	logic                    above_range;

	bit [TIME_W-1:0]        bp_time [TABLE_DEPTH];
	bit signed [VAL_W-1:0]  bp_value [TABLE_DEPTH];
	logic [CNT_W-1:0]       count_reg = COUNT_RESET;
	interp_result_t         expected_results [$];
	int unsigned            words_sent = 0;
	int unsigned            mismatches = 0;

	piecewise_linear_table_interp_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.point_index  (point_index),
		.point_time   (point_time),
		.point_value  (point_value),
		.query_time   (query_time),
		.done         (done),
		.result_value (result_value),
		.below_range  (below_range),
		.above_range  (above_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void add_expected(input interp_result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic interp_result_t interpolate_at(input logic [TIME_W-1:0] qt);
		interp_result_t r;
		int unsigned n, last, lo, hi, mid;
		logic [TIME_W-1:0] t1, t2, tc;
		longint num;
		r = '0;
		n = (count_reg == 0) ? 1 : (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
		last = n - 1;
		if (qt < bp_time[0]) begin
			r.value = bp_value[0];
			r.below = 1'b1;
		end else if (qt > bp_time[last]) begin
			r.value = bp_value[last];
			r.above = 1'b1;
		end else if (last == 0) begin
			r.value = bp_value[0];
		end else begin
			lo = 0;
			hi = last;
			mid = (lo + hi) / 2;
			do begin
				if (qt > bp_time[mid])
					lo = mid;
				else
					hi = mid;
				mid = (lo + hi) / 2;
			end while (mid != lo);
			t1 = bp_time[lo];
			t2 = bp_time[lo + 1];
			if (t2 <= t1) begin
				r.value = bp_value[lo];
			end else begin
				// clamp into the chosen interval for out-of-order tables
				tc = (qt < t1) ? t1 : (qt > t2) ? t2 : qt;
				num = longint'({32'd0, t2 - tc}) * longint'(bp_value[lo])
					+ longint'({32'd0, tc - t1}) * longint'(bp_value[lo + 1]);
				r.value = VAL_W'(num / longint'({32'd0, t2 - t1}));
			end
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_query(input int unsigned n);
		int unsigned k;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return bp_time[k];
			2: return bp_time[k] + 1;
			3: return bp_time[k] - 1;
			4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			default: return $urandom_range(bp_time[0], bp_time[n - 1]);
		endcase
	endfunction

	task automatic send_word(input logic fn, input logic [7:0] idx,
			input logic [TIME_W-1:0] pt, input logic [VAL_W-1:0] pv,
			input logic [TIME_W-1:0] qt, input logic typed, input interp_result_t want);
		// no idling in a stretch of the random part
		while (!(words_sent >= 500 && words_sent < 750)
				&& $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		point_index <= idx;
		point_time <= pt;
		point_value <= pv;
		query_time <= qt;
		do @(posedge clk); while (busy);
		if (fn == FUNC_WRITE) begin
			bp_time[idx] = pt;
			bp_value[idx] = pv;
		end else if (typed) begin
			add_expected(want);
		end else begin
			add_expected(interpolate_at(qt));
		end
		words_sent++;
	endtask

	task automatic set_point_count(input logic [CNT_W-1:0] c);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = c;
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] cfg_value);
		int unsigned n, step_max, k, nq, mode;
		logic [TIME_W:0] acc;
		logic [TIME_W-1:0] t_now, pt;
		logic [TIME_W-1:0] times [TABLE_DEPTH];
		set_point_count(cfg_value);
		n = (cfg_value == 0) ? 1 : (cfg_value > TABLE_DEPTH) ? TABLE_DEPTH : cfg_value;
		mode = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: step_max = 3;
			1: step_max = 1000;
			2: step_max = 32'h0010_0000;
			default: step_max = 32'hFFFF_FFFF / n;
		endcase
		t_now = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, 32'h7FFF_FFFF);
		for (k = 0; k < n; k++) begin
			times[k] = t_now;
			acc = t_now + $urandom_range(0, step_max);
			t_now = acc[TIME_W] ? 32'hFFFF_FFFF : acc[TIME_W-1:0];
		end
		// mostly ascending tables, some scrambled or descending
		for (k = 0; k < n; k++) begin
			pt = (mode == 0) ? $urandom : (mode == 1) ? times[n - 1 - k] : times[k];
			send_word(FUNC_WRITE, 8'(k), pt, pick_value(), $urandom, 1'b0, '0);
		end
		nq = $urandom_range(6, 24);
		for (k = 0; k < nq; k++) begin
			if ($urandom_range(0, 11) == 0)
				send_word(FUNC_WRITE, 8'($urandom), $urandom, pick_value(), $urandom,
					1'b0, '0);
			else
				send_word(FUNC_QUERY, 8'($urandom), $urandom, $urandom, pick_query(n),
					1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		interp_result_t want;
		if (done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected word: value %h below %b above %b",
						result_value, below_range, above_range);
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.value || below_range !== want.below
						|| above_range !== want.above) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected %h/%b/%b, got %h/%b/%b",
							want.value, want.below, want.above,
							result_value, below_range, above_range);
				end
			end
		end
	end

	initial begin
		int unsigned phase;
		logic [CNT_W-1:0] cfg_value;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_COUNT)
				set_point_count(PLAN[r].count);
			else
				send_word(PLAN[r].fn, PLAN[r].idx, PLAN[r].pt, PLAN[r].pv, PLAN[r].qt,
					PLAN[r].typed,
					interp_result_t'{PLAN[r].exp_val, PLAN[r].exp_below, PLAN[r].exp_above});
		end

		words_sent = 0;
		phase = 0;
		while (words_sent < WORD_TARGET) begin
			case (phase)
				0: cfg_value = 9'd256;
				1: cfg_value = 9'd511;
				default: begin
					case ($urandom_range(0, 29))
						0: cfg_value = 9'd256;
						1: cfg_value = $urandom_range(257, 511);
						2: cfg_value = 9'd0;
						3: cfg_value = 9'd1;
						4, 5, 6: cfg_value = $urandom_range(10, 40);
						default: cfg_value = $urandom_range(2, 9);
					endcase
				end
			endcase
			run_phase(cfg_value);
			phase++;
		end

		start <= 1'b0;
		while (expected_results.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
